@@ hw/rtl/ole_pkg.sv @@
// Shared types and codes for the ordered list engine.
package ole_pkg;

   localparam int VALUE_W  = 32;
   localparam int OPCODE_W = 3;
   localparam int POS_W    = 8;
   localparam int STATUS_W = 3;

   localparam logic [OPCODE_W-1:0] OP_INS_FRONT = 3'd0;
   localparam logic [OPCODE_W-1:0] OP_INS_BACK  = 3'd1;
   localparam logic [OPCODE_W-1:0] OP_INS_AT    = 3'd2;
   localparam logic [OPCODE_W-1:0] OP_DELETE    = 3'd3;
   localparam logic [OPCODE_W-1:0] OP_READ_FWD  = 3'd4;
   localparam logic [OPCODE_W-1:0] OP_READ_REV  = 3'd5;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK       = 3'd0,
      STAT_BADPOS   = 3'd1,
      STAT_EMPTY    = 3'd2,
      STAT_NOTFOUND = 3'd3,
      STAT_FULL     = 3'd4
   } status_type;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_SEARCH = 5'b00010,
      ST_SHIFT  = 5'b00100,
      ST_READ   = 5'b01000,
      ST_RESP   = 5'b10000
   } state_type;

endpackage

@@ hw/rtl/ole_store.sv @@
// Entry memory: one write port, one read port with registered read data.
module ole_store #(
   parameter int DEPTH = 32,
   parameter int AW    = 5,
   parameter int DW    = 32
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [DW-1:0] wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [DW-1:0] rd_data
);

   logic [DW-1:0] mem_ff [DEPTH];
   logic [DW-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Hold the last word read until the next read.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hw/rtl/ordered_list_engine.sv @@
// Ordered list engine: bounded list of signed 32-bit entries held in one memory.
//
// Input channel req_*: one word carries an opcode (insert front, insert back,
// insert at a 1-based position, delete first match, read forward, read reverse),
// a value and a position. req_ready is high only while the sequencer is idle.
// Result channel rsp_*: inserts and deletes give one status word; a read gives
// one word per entry with rsp_last_item on the final one, or one empty status.
// Opcodes 6 and 7 are taken and give no word.
// Work per request, with n entries held in the one memory:
//   insert at slot i: the n-i entries from slot i onward each move up one,
//   one move per cycle, then the value is written and the status sent;
//   delete: a search from the front, then on a match every later entry moves
//   down one and an OK status is sent, else a not-found status; read: one
//   entry word per cycle while the receiver takes them; delete or read on
//   an empty list: one empty status.
// A stalled receiver holds the output register; reads then pause and resume.
// Reset empties the list at once; no clearing pass is needed.
module ordered_list_engine
   import ole_pkg::*;
#(
   parameter int CAPACITY = 32
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [OPCODE_W-1:0]        req_opcode,
   input  logic signed [VALUE_W-1:0]  req_item_value,
   input  logic [POS_W-1:0]           req_position,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [STATUS_W-1:0]        rsp_status,
   output logic signed [VALUE_W-1:0]  rsp_out_value,
   output logic                       rsp_last_item
);

   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int PW = (CW + 1 > POS_W + 1) ? CW + 1 : POS_W + 1;
   localparam logic [CW-1:0] CAP_COUNT = CW'(CAPACITY);

   state_type            state_ff, state_in;
   logic [CW-1:0]        count_ff, count_in;
   logic [VALUE_W-1:0]   val_ff, val_in;
   logic                 ins_ff, ins_in;
   logic                 dec_ff, dec_in;
   logic [CW-1:0]        idx_ff, idx_in;
   logic [CW-1:0]        addr_ff, addr_in;
   logic [CW-1:0]        left_ff, left_in;
   logic                 rdv_ff, rdv_in;
   logic [CW-1:0]        ridx_ff, ridx_in;
   logic                 pend_ff, pend_in;
   logic                 plast_ff, plast_in;
   status_type           stat_ff, stat_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]  rsp_status_ff, rsp_status_in;
   logic [VALUE_W-1:0]   rsp_value_ff, rsp_value_in;
   logic                 rsp_last_ff, rsp_last_in;

   logic                 wr_en;
   logic [AW-1:0]        wr_addr;
   logic [VALUE_W-1:0]   wr_data;
   logic                 rd_en;
   logic [VALUE_W-1:0]   rd_data;
   logic                 out_free;
   logic                 issue;
   logic                 load_rd;
   logic [CW-1:0]        addr_step;
   logic [CW-1:0]        dst;
   logic [PW-1:0]        pos_ext;
   logic [PW-1:0]        limit_ext;

   ole_store #(
      .DEPTH (CAPACITY),
      .AW    (AW),
      .DW    (VALUE_W)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (addr_ff[AW-1:0]),
      .rd_data (rd_data)
   );

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign issue     = (left_ff != '0);
   assign addr_step = dec_ff ? (addr_ff - CW'(1)) : (addr_ff + CW'(1));
   assign dst       = dec_ff ? (ridx_ff + CW'(1)) : (ridx_ff - CW'(1));
   assign pos_ext   = PW'(req_position);
   assign limit_ext = PW'(count_ff) + PW'(1);

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      val_in    = val_ff;
      ins_in    = ins_ff;
      dec_in    = dec_ff;
      idx_in    = idx_ff;
      addr_in   = addr_ff;
      left_in   = left_ff;
      rdv_in    = rdv_ff;
      ridx_in   = ridx_ff;
      pend_in   = pend_ff;
      plast_in  = plast_ff;
      stat_in   = stat_ff;
      req_ready = 1'b0;
      rd_en     = 1'b0;
      wr_en     = 1'b0;
      wr_addr   = dst[AW-1:0];
      wr_data   = rd_data;
      load_rd   = 1'b0;

      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_last_in   = rsp_last_ff;

      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               val_in  = req_item_value;
               rdv_in  = 1'b0;
               pend_in = 1'b0;
               case (req_opcode)
                  OP_INS_FRONT, OP_INS_BACK, OP_INS_AT: begin
                     ins_in = 1'b1;
                     dec_in = 1'b1;
                     if (count_ff == CAP_COUNT) begin
                        stat_in  = STAT_FULL;
                        state_in = ST_RESP;
                     end else if (req_opcode == OP_INS_AT && pos_ext > limit_ext) begin
                        stat_in  = STAT_BADPOS;
                        state_in = ST_RESP;
                     end else begin
                        if (req_opcode == OP_INS_BACK) begin
                           idx_in = count_ff;
                        end else if (req_opcode == OP_INS_AT && req_position > POS_W'(1)) begin
                           idx_in = CW'(req_position - POS_W'(1));
                        end else begin
                           idx_in = '0;
                        end
                        left_in  = count_ff - idx_in;
                        addr_in  = count_ff - CW'(1);
                        state_in = ST_SHIFT;
                     end
                  end
                  OP_DELETE: begin
                     ins_in = 1'b0;
                     dec_in = 1'b0;
                     if (count_ff == '0) begin
                        stat_in  = STAT_EMPTY;
                        state_in = ST_RESP;
                     end else begin
                        addr_in  = '0;
                        left_in  = count_ff;
                        state_in = ST_SEARCH;
                     end
                  end
                  OP_READ_FWD, OP_READ_REV: begin
                     ins_in = 1'b0;
                     dec_in = (req_opcode == OP_READ_REV);
                     if (count_ff == '0) begin
                        stat_in  = STAT_EMPTY;
                        state_in = ST_RESP;
                     end else begin
                        addr_in  = (req_opcode == OP_READ_REV) ? (count_ff - CW'(1)) : '0;
                        left_in  = count_ff;
                        state_in = ST_READ;
                     end
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end

         ST_SEARCH: begin
            if (rdv_ff && rd_data == val_ff) begin
               // Match: close the gap by moving every later entry down one.
               addr_in  = ridx_ff + CW'(1);
               left_in  = count_ff - ridx_ff - CW'(1);
               dec_in   = 1'b0;
               rdv_in   = 1'b0;
               state_in = ST_SHIFT;
            end else if (issue) begin
               rd_en   = 1'b1;
               addr_in = addr_step;
               left_in = left_ff - CW'(1);
               rdv_in  = 1'b1;
               ridx_in = addr_ff;
            end else begin
               rdv_in   = 1'b0;
               stat_in  = STAT_NOTFOUND;
               state_in = ST_RESP;
            end
         end

         ST_SHIFT: begin
            if (rdv_ff) begin
               wr_en = 1'b1;
            end
            if (issue) begin
               rd_en   = 1'b1;
               addr_in = addr_step;
               left_in = left_ff - CW'(1);
               rdv_in  = 1'b1;
               ridx_in = addr_ff;
            end else begin
               rdv_in = 1'b0;
               if (!rdv_ff) begin
                  if (ins_ff) begin
                     wr_en    = 1'b1;
                     wr_addr  = idx_ff[AW-1:0];
                     wr_data  = val_ff;
                     count_in = count_ff + CW'(1);
                  end else begin
                     count_in = count_ff - CW'(1);
                  end
                  stat_in  = STAT_OK;
                  state_in = ST_RESP;
               end
            end
         end

         ST_READ: begin
            load_rd = pend_ff && out_free;
            if (issue && (!pend_ff || load_rd)) begin
               rd_en    = 1'b1;
               addr_in  = addr_step;
               left_in  = left_ff - CW'(1);
               plast_in = (left_ff == CW'(1));
               pend_in  = 1'b1;
            end else if (load_rd) begin
               pend_in = 1'b0;
            end
            if (!issue && !pend_ff) begin
               state_in = ST_IDLE;
            end
         end

         ST_RESP: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = stat_ff;
               rsp_value_in  = '0;
               rsp_last_in   = 1'b1;
               state_in      = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (load_rd) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = STAT_OK;
         rsp_value_in  = rd_data;
         rsp_last_in   = plast_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rdv_ff       <= 1'b0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         left_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rdv_ff       <= rdv_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
         left_ff      <= left_in;
      end
   end

   always_ff @(posedge clock) begin
      val_ff        <= val_in;
      ins_ff        <= ins_in;
      dec_ff        <= dec_in;
      idx_ff        <= idx_in;
      addr_ff       <= addr_in;
      ridx_ff       <= ridx_in;
      plast_ff      <= plast_in;
      stat_ff       <= stat_in;
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_out_value = rsp_value_ff;
   assign rsp_last_item = rsp_last_ff;

endmodule
